/* hdl/segment_display_serial_writer_unit_assert.svh */
// assertion macros shared by the display writer
`ifndef SEGMENT_DISPLAY_SERIAL_WRITER_UNIT_ASSERT_SVH
`define SEGMENT_DISPLAY_SERIAL_WRITER_UNIT_ASSERT_SVH

// same-cycle implication, checked on every clock edge out of reset
`define SDW_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication
`define SDW_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* hdl/sdw_pkg.sv */
package sdw_pkg;

  // fixed byte and fixed high-bit prefixes of the protocol
  localparam logic [7:0] CmdFixedAddr = 8'h44;
  localparam logic [4:0] AddrBaseHi   = 5'b11000;
  localparam logic [3:0] CtrlBaseHi   = 4'b1000;

  // configuration register indexes
  localparam logic [1:0] RegBrightness = 2'd0;
  localparam logic [1:0] RegDisplayOn  = 2'd1;
  localparam logic [1:0] RegAckTimeout = 2'd2;

  localparam int unsigned CfgDataWidth = 10;

  // reset values of the configuration
  localparam logic [2:0] BrightnessRst = 3'd7;
  localparam logic       DisplayOnRst  = 1'b1;
  localparam logic [9:0] AckTimeoutRst = 10'd256;

  // tick delays
  localparam logic [2:0] DlyStart = 3'd2;
  localparam logic [2:0] DlyBit   = 3'd3;
  localparam logic [2:0] DlyAck   = 3'd2;
  localparam logic [2:0] DlyAckHi = 3'd5;
  localparam logic [2:0] DlyStop  = 3'd2;

  typedef enum logic [3:0] {
    PhIdle,
    PhStartA,
    PhStartB,
    PhBitA,
    PhBitB,
    PhAckA,
    PhAckPoll,
    PhAckEnd,
    PhStopA,
    PhStopB,
    PhStopC,
    PhStopD
  } phase_e;

  typedef struct packed {
    logic       mode;
    logic [2:0] digit_position;
    logic [7:0] segments;
    logic       dio_in;
  } in_item_t;

  typedef struct packed {
    logic clk_out;
    logic dio_out;
    logic busy_res;
    logic done_res;
    logic ack_missing;
    logic request_dropped;
  } out_item_t;

  typedef struct packed {
    logic [2:0] brightness;
    logic       display_on;
    logic [9:0] ack_timeout;
  } cfg_t;

endpackage

/* hdl/sdw_cfg_regs.sv */
module sdw_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [1:0]                          cfg_index_i,
  input  logic [sdw_pkg::CfgDataWidth-1:0]    cfg_data_i,
  output sdw_pkg::cfg_t                       cfg_o
);

  sdw_pkg::cfg_t cfg_q, cfg_d;

  // register write decode, unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        sdw_pkg::RegBrightness: cfg_d.brightness  = cfg_data_i[2:0];
        sdw_pkg::RegDisplayOn:  cfg_d.display_on  = cfg_data_i[0];
        sdw_pkg::RegAckTimeout: cfg_d.ack_timeout = cfg_data_i[9:0];
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.brightness  <= sdw_pkg::BrightnessRst;
      cfg_q.display_on  <= sdw_pkg::DisplayOnRst;
      cfg_q.ack_timeout <= sdw_pkg::AckTimeoutRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hdl/sdw_seq.sv */
module sdw_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  sdw_pkg::in_item_t   item_i,
  input  sdw_pkg::cfg_t       cfg_i,
  output sdw_pkg::out_item_t  res_o
);

  sdw_pkg::phase_e phase_q, phase_d;
  logic [2:0] delay_q, delay_d;
  logic [2:0] bit_idx_q, bit_idx_d;
  logic [7:0] shift_q, shift_d;
  logic [1:0] trans_q, trans_d;
  logic       byte_sel_q, byte_sel_d;
  logic [9:0] poll_q, poll_d;
  logic [7:0] addr_q, addr_d;
  logic [7:0] seg_q, seg_d;
  logic       ack_flag_q, ack_flag_d;
  logic       clk_lvl_q, clk_lvl_d;
  logic       dio_lvl_q, dio_lvl_d;
  logic       done, dropped;
  logic [9:0] poll_inc;
  logic [7:0] first_byte;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= sdw_pkg::PhIdle;
      delay_q    <= '0;
      bit_idx_q  <= '0;
      shift_q    <= '0;
      trans_q    <= '0;
      byte_sel_q <= 1'b0;
      poll_q     <= '0;
      addr_q     <= '0;
      seg_q      <= '0;
      ack_flag_q <= 1'b0;
      clk_lvl_q  <= 1'b1;
      dio_lvl_q  <= 1'b1;
    end else begin
      phase_q    <= phase_d;
      delay_q    <= delay_d;
      bit_idx_q  <= bit_idx_d;
      shift_q    <= shift_d;
      trans_q    <= trans_d;
      byte_sel_q <= byte_sel_d;
      poll_q     <= poll_d;
      addr_q     <= addr_d;
      seg_q      <= seg_d;
      ack_flag_q <= ack_flag_d;
      clk_lvl_q  <= clk_lvl_d;
      dio_lvl_q  <= dio_lvl_d;
    end
  end

  // first byte of the current transaction
  always_comb begin
    case (trans_q)
      2'd0:    first_byte = sdw_pkg::CmdFixedAddr;
      2'd1:    first_byte = addr_q;
      default: first_byte = {sdw_pkg::CtrlBaseHi, cfg_i.display_on, cfg_i.brightness};
    endcase
  end

  assign poll_inc = poll_q + 10'd1;

  // next state and result of one transfer
  always_comb begin
    phase_d    = phase_q;
    delay_d    = delay_q;
    bit_idx_d  = bit_idx_q;
    shift_d    = shift_q;
    trans_d    = trans_q;
    byte_sel_d = byte_sel_q;
    poll_d     = poll_q;
    addr_d     = addr_q;
    seg_d      = seg_q;
    ack_flag_d = ack_flag_q;
    clk_lvl_d  = clk_lvl_q;
    dio_lvl_d  = dio_lvl_q;
    done       = 1'b0;
    dropped    = 1'b0;

    if (step_i) begin
      if (item_i.mode) begin
        // write request: refused while a sequence runs
        if (phase_q != sdw_pkg::PhIdle) begin
          dropped = 1'b1;
        end else begin
          addr_d     = {sdw_pkg::AddrBaseHi, item_i.digit_position};
          seg_d      = item_i.segments;
          ack_flag_d = 1'b0;
          trans_d    = '0;
          byte_sel_d = 1'b0;
          bit_idx_d  = '0;
          delay_d    = '0;
          poll_d     = '0;
          phase_d    = sdw_pkg::PhStartA;
        end
      end else if (phase_q != sdw_pkg::PhIdle) begin
        if (delay_q != 3'd0) begin
          delay_d = delay_q - 3'd1;
        end else begin
          case (phase_q)
            sdw_pkg::PhStartA: begin
              clk_lvl_d = 1'b1;
              dio_lvl_d = 1'b1;
              delay_d   = sdw_pkg::DlyStart;
              phase_d   = sdw_pkg::PhStartB;
            end
            sdw_pkg::PhStartB: begin
              dio_lvl_d  = 1'b0;
              shift_d    = first_byte;
              byte_sel_d = 1'b0;
              bit_idx_d  = '0;
              phase_d    = sdw_pkg::PhBitA;
            end
            sdw_pkg::PhBitA: begin
              clk_lvl_d = 1'b0;
              dio_lvl_d = shift_q[0];
              delay_d   = sdw_pkg::DlyBit;
              phase_d   = sdw_pkg::PhBitB;
            end
            sdw_pkg::PhBitB: begin
              shift_d   = {1'b0, shift_q[7:1]};
              clk_lvl_d = 1'b1;
              delay_d   = sdw_pkg::DlyBit;
              if (bit_idx_q == 3'd7) begin
                phase_d = sdw_pkg::PhAckA;
              end else begin
                bit_idx_d = bit_idx_q + 3'd1;
                phase_d   = sdw_pkg::PhBitA;
              end
            end
            sdw_pkg::PhAckA: begin
              clk_lvl_d = 1'b0;
              dio_lvl_d = 1'b1;
              delay_d   = sdw_pkg::DlyAck;
              poll_d    = '0;
              phase_d   = sdw_pkg::PhAckPoll;
            end
            sdw_pkg::PhAckPoll: begin
              // low dio ends the ack, otherwise count high polls to the timeout
              if (!item_i.dio_in) begin
                clk_lvl_d = 1'b1;
                delay_d   = sdw_pkg::DlyAckHi;
                phase_d   = sdw_pkg::PhAckEnd;
              end else begin
                poll_d = poll_inc;
                if (poll_inc >= cfg_i.ack_timeout) begin
                  ack_flag_d = 1'b1;
                  clk_lvl_d  = 1'b1;
                  delay_d    = sdw_pkg::DlyAckHi;
                  phase_d    = sdw_pkg::PhAckEnd;
                end
              end
            end
            sdw_pkg::PhAckEnd: begin
              clk_lvl_d = 1'b0;
              if (trans_q == 2'd1 && !byte_sel_q) begin
                byte_sel_d = 1'b1;
                shift_d    = seg_q;
                bit_idx_d  = '0;
                phase_d    = sdw_pkg::PhBitA;
              end else begin
                phase_d = sdw_pkg::PhStopA;
              end
            end
            sdw_pkg::PhStopA: begin
              clk_lvl_d = 1'b0;
              delay_d   = sdw_pkg::DlyStop;
              phase_d   = sdw_pkg::PhStopB;
            end
            sdw_pkg::PhStopB: begin
              dio_lvl_d = 1'b0;
              delay_d   = sdw_pkg::DlyStop;
              phase_d   = sdw_pkg::PhStopC;
            end
            sdw_pkg::PhStopC: begin
              clk_lvl_d = 1'b1;
              delay_d   = sdw_pkg::DlyStop;
              phase_d   = sdw_pkg::PhStopD;
            end
            sdw_pkg::PhStopD: begin
              dio_lvl_d = 1'b1;
              if (trans_q >= 2'd2) begin
                trans_d = '0;
                phase_d = sdw_pkg::PhIdle;
                done    = 1'b1;
              end else begin
                trans_d = trans_q + 2'd1;
                phase_d = sdw_pkg::PhStartA;
              end
            end
            default: begin
              phase_d = sdw_pkg::PhIdle;
            end
          endcase
        end
      end
    end
  end

  // result reflects the levels after this transfer
  always_comb begin
    res_o.clk_out         = clk_lvl_d;
    res_o.dio_out         = dio_lvl_d;
    res_o.busy_res        = (phase_d != sdw_pkg::PhIdle);
    res_o.done_res        = done;
    res_o.ack_missing     = ack_flag_d;
    res_o.request_dropped = dropped;
  end

endmodule

/* hdl/segment_display_serial_writer_unit.sv */
// Two-wire seven-segment display writer. Each input transfer is either one
// time tick or a digit write request; every transfer yields exactly one result
// carrying the CLK and DIO levels and the status flags after it is handled.
// A request starts three bus transactions (fixed-address command, address plus
// segment byte, display control) that advance one step per tick; requests that
// arrive while a sequence runs are refused and flagged. The block takes one
// transfer per clock cycle unless the output stalls: an input register feeds
// the sequencer step, whose result lands in an output register, and a stalled
// output only holds the input side once both registers are full. Configuration
// writes take effect on the next cycle and should be made while idle.
module segment_display_serial_writer_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  sdw_pkg::in_item_t                 in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output sdw_pkg::out_item_t                out_item_o,
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_index_i,
  input  logic [sdw_pkg::CfgDataWidth-1:0]  cfg_data_i
);

  `include "segment_display_serial_writer_unit_assert.svh"

  logic               in_valid_q, in_valid_d;
  sdw_pkg::in_item_t  in_item_q;
  logic               out_valid_q, out_valid_d;
  sdw_pkg::out_item_t out_item_q;
  sdw_pkg::out_item_t step_res;
  sdw_pkg::cfg_t      cfg;
  logic               out_free;
  logic               step;
  logic               in_take;

  // handshake between the two register stages
  assign out_free    = !out_valid_q || !out_stall_i;
  assign step        = in_valid_q && out_free;
  assign in_take     = !in_valid_q || step;
  assign in_stall_o  = !in_take;
  assign in_valid_d  = (in_valid_i && in_take) || (in_valid_q && !step);
  assign out_valid_d = step || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_take) begin
      in_item_q <= in_item_i;
    end
    if (step) begin
      out_item_q <= step_res;
    end
  end

  sdw_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  sdw_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_item_q),
    .cfg_i  (cfg),
    .res_o  (step_res)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // checks on sequencer results and stage hand-off
  `SDW_ASSERT_IMP(a_done_not_busy, out_valid_q && out_item_q.done_res, !out_item_q.busy_res)
  `SDW_ASSERT_IMP(a_drop_when_busy, out_valid_q && out_item_q.request_dropped,
                  out_item_q.busy_res && !out_item_q.done_res)
  `SDW_ASSERT_NXT(a_in_stage_holds, in_valid_q && !out_free, in_valid_q)

endmodule
